[src/rcw_pkg.sv]
package rcw_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_FRAC      = 16;

  localparam int COL_W   = 12;
  localparam int CELL_W  = 8;
  localparam int POS_W   = 24;
  localparam int RAY_W   = 20;
  localparam int FH_W    = 12;
  localparam int TEX_W   = 11;
  localparam int ROW_W   = 11;
  localparam int H_W     = 20;
  localparam int TX_W    = 10;
  localparam int Q_W     = 32;
  localparam int STEP_NQ = TEX_W + OUT_FRAC;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST   = FH_W'(480);
  localparam logic [TEX_W-1:0] TEXTURE_WIDTH_RST  = TEX_W'(64);
  localparam logic [TEX_W-1:0] TEXTURE_HEIGHT_RST = TEX_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_HEIGHT   = 2'd0,
    REG_TEXTURE_WIDTH  = 2'd1,
    REG_TEXTURE_HEIGHT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [COL_W-1:0]         column;
    logic                     hit_y_side;
    logic [CELL_W-1:0]        cell_x;
    logic [CELL_W-1:0]        cell_y;
    logic [POS_W-1:0]         player_x;
    logic [POS_W-1:0]         player_y;
    logic signed [RAY_W-1:0]  ray_x;
    logic signed [RAY_W-1:0]  ray_y;
    logic                     step_x_negative;
    logic                     step_y_negative;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]        column_out;
    logic [ROW_W-1:0]        row_first;
    logic [ROW_W-1:0]        row_last;
    logic [H_W-1:0]          slice_height;
    logic [TX_W-1:0]         texture_column;
    logic [Q_W-1:0]          texture_step;
    logic signed [Q_W-1:0]   texture_start;
  } out_item_t;

endpackage

[src/rcw_chan_if.sv]
interface rcw_chan_if #(parameter type item_t = logic) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[src/rcw_div_cell.sv]
// One restoring division step: brings in the next numerator bit, subtracts
// the divisor if it fits, shifts the quotient bit in at the bottom.
module rcw_div_cell #(
  parameter int NQ = 32,
  parameter int DW = 20,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [NQ-1:0] in_num,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_rem,
  output logic [NQ-1:0] out_num,
  output logic [DW-1:0] out_div,
  output logic [SW-1:0] out_side
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic [DW-1:0] rem_next;

  always_comb begin
    trial    = {in_rem, in_num[NQ-1]};
    diff     = trial - {1'b0, in_div};
    fits     = trial >= {1'b0, in_div};
    rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_num  <= {in_num[NQ-2:0], fits};
      out_div  <= in_div;
      out_side <= in_side;
    end
  end

endmodule

[src/rcw_div_chain.sv]
// Row of NQ division cells, one quotient bit per cell, MSB first.
module rcw_div_chain #(
  parameter int NQ = 32,
  parameter int DW = 20,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NQ-1:0] in_num,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NQ-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          valid [NQ+1];
  logic [DW-1:0] rem   [NQ+1];
  logic [NQ-1:0] num   [NQ+1];
  logic [DW-1:0] div   [NQ+1];
  logic [SW-1:0] side  [NQ+1];

  assign valid[0] = in_valid;
  assign rem[0]   = '0;
  assign num[0]   = in_num;
  assign div[0]   = in_div;
  assign side[0]  = in_side;

  for (genvar i = 0; i < NQ; i++) begin : g_cell
    rcw_div_cell #(.NQ(NQ), .DW(DW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (valid[i]),
      .in_rem   (rem[i]),
      .in_num   (num[i]),
      .in_div   (div[i]),
      .in_side  (side[i]),
      .out_valid(valid[i+1]),
      .out_rem  (rem[i+1]),
      .out_num  (num[i+1]),
      .out_div  (div[i+1]),
      .out_side (side[i+1])
    );
  end

  assign out_valid = valid[NQ];
  assign out_quo   = num[NQ];
  assign out_side  = side[NQ];

endmodule

[src/raycast_wall_column_setup.sv]
// Wall column setup for a grid raycaster. Each input item is one screen
// column's ray hit; each result item is that column's wall span (start and
// end row, slice height), its texture column and the texture row step and
// start in Q16.16. One item is accepted every clock while the output is not
// stalled; a stall on the output holds the whole pipeline. The pipeline is
// the input register and the numerator multiply, then two rows of division
// cells, one quotient bit per cell, for the slice height and the hit offset
// (run side by side, NB cells each, NB = max(FRAC_BITS + 9, 24) + 20 = 45
// at FRAC_BITS = 16), then a row of 27 cells for the texture step, plus two
// post-division stages, the texture-start multiply and the output register.
// Configuration registers are read live, so write them only while idle.
module raycast_wall_column_setup #(
  parameter int FRAC_BITS = rcw_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcw_pkg::CFG_DATA_W-1:0] cfg_data,
  rcw_chan_if.sink                       in_ch,
  rcw_chan_if.source                     out_ch
);

  import rcw_pkg::*;

  // distance magnitude width and the width of the offset-division numerator
  localparam int MW   = (FRAC_BITS + 9 > POS_W) ? FRAC_BITS + 9 : POS_W;
  localparam int NB   = MW + RAY_W;
  localparam int NA_W = FH_W + RAY_W;
  localparam int PM_W = H_W + 1 + Q_W;
  localparam int TP_W = FRAC_BITS + TEX_W;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             d_zero;
    logic             r_zero;
  } side_a_t;

  typedef struct packed {
    logic [POS_W-1:0] pb;
    logic             rb_neg;
    logic             mirror;
  } side_b_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] ls;
    logic [ROW_W-1:0] le;
    logic [H_W-1:0]   h;
    logic [TX_W-1:0]  tx;
  } side_s_t;

  // ---------------- configuration ----------------
  logic [FH_W-1:0]  fh;
  logic [TEX_W-1:0] tw;
  logic [TEX_W-1:0] th;

  always_ff @(posedge clk) begin
    if (rst) begin
      fh <= FRAME_HEIGHT_RST;
      tw <= TEXTURE_WIDTH_RST;
      th <= TEXTURE_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_HEIGHT:   fh <= cfg_data[FH_W-1:0];
        REG_TEXTURE_WIDTH:  tw <= cfg_data[TEX_W-1:0];
        REG_TEXTURE_HEIGHT: th <= cfg_data[TEX_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output item is stuck
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- stage 0: select axis, distance, magnitudes ----------------
  in_item_t         di;
  logic [CELL_W:0]  cell9;
  logic [POS_W-1:0] pa, pb;
  logic [RAY_W-1:0] ra, rb;
  logic [MW-1:0]    cellw, paw, dm_in;
  logic [RAY_W-1:0] ram_in, rbm_in;
  logic             mirror_in;

  always_comb begin
    di    = in_ch.data;
    cell9 = di.hit_y_side ? ({1'b0, di.cell_y} + (CELL_W+1)'(di.step_y_negative))
                          : ({1'b0, di.cell_x} + (CELL_W+1)'(di.step_x_negative));
    pa    = di.hit_y_side ? di.player_y : di.player_x;
    pb    = di.hit_y_side ? di.player_x : di.player_y;
    ra    = di.hit_y_side ? di.ray_y : di.ray_x;
    rb    = di.hit_y_side ? di.ray_x : di.ray_y;
    cellw = MW'(cell9) << FRAC_BITS;
    paw   = MW'(pa);
    dm_in = (cellw >= paw) ? cellw - paw : paw - cellw;
    ram_in = ra[RAY_W-1] ? (~ra + 1'b1) : ra;
    rbm_in = rb[RAY_W-1] ? (~rb + 1'b1) : rb;
    // texture mirrored on an x face when ray_x > 0, on a y face when ray_y < 0
    mirror_in = di.hit_y_side ? di.ray_y[RAY_W-1]
                              : (!di.ray_x[RAY_W-1] && (di.ray_x != '0));
  end

  logic             s0_valid;
  logic [COL_W-1:0] s0_col;
  logic [MW-1:0]    s0_dm;
  logic [RAY_W-1:0] s0_ram, s0_rbm;
  logic [POS_W-1:0] s0_pb;
  logic             s0_rb_neg, s0_mirror;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_col    <= di.column;
      s0_dm     <= dm_in;
      s0_ram    <= ram_in;
      s0_rbm    <= rbm_in;
      s0_pb     <= pb;
      s0_rb_neg <= rb[RAY_W-1];
      s0_mirror <= mirror_in;
    end
  end

  // ---------------- stage 1: numerators ----------------
  logic             s1_valid;
  logic [NA_W-1:0]  s1_numa;
  logic [NB-1:0]    s1_numb;
  logic [MW-1:0]    s1_dm;
  logic [RAY_W-1:0] s1_ram;
  side_a_t          s1_sa;
  side_b_t          s1_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_numa   <= NA_W'(fh) * NA_W'(s0_ram);
      s1_numb   <= NB'(s0_dm) * NB'(s0_rbm);
      s1_dm     <= s0_dm;
      s1_ram    <= s0_ram;
      s1_sa.col    <= s0_col;
      s1_sa.d_zero <= (s0_dm == '0);
      s1_sa.r_zero <= (s0_ram == '0);
      s1_sb.pb     <= s0_pb;
      s1_sb.rb_neg <= s0_rb_neg;
      s1_sb.mirror <= s0_mirror;
    end
  end

  // ---------------- height and offset divisions, side by side ----------------
  logic          a_valid, b_valid;
  logic [NB-1:0] a_quo, b_quo;
  side_a_t       a_side;
  side_b_t       b_side;

  rcw_div_chain #(.NQ(NB), .DW(MW), .SW($bits(side_a_t))) u_div_height (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s1_valid),
    .in_num   (NB'(s1_numa)),
    .in_div   (s1_dm),
    .in_side  (s1_sa),
    .out_valid(a_valid),
    .out_quo  (a_quo),
    .out_side (a_side)
  );

  rcw_div_chain #(.NQ(NB), .DW(RAY_W), .SW($bits(side_b_t))) u_div_offset (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s1_valid),
    .in_num   (s1_numb),
    .in_div   (s1_ram),
    .in_side  (s1_sb),
    .out_valid(b_valid),
    .out_quo  (b_quo),
    .out_side (b_side)
  );

  // ---------------- stage 2: height, span, texture column ----------------
  logic [H_W-1:0]       cap, h2;
  logic [ROW_W-1:0]     mid, ls2, le2;
  logic [H_W-2:0]       half;
  logic [H_W-1:0]       le_sum;
  logic [FH_W-1:0]      le_c;
  logic [FRAC_BITS-1:0] frac, offl;
  logic [TP_W-1:0]      tprod;
  logic [TEX_W-1:0]     t0, tm;
  logic [TX_W-1:0]      tx2;

  always_comb begin
    cap = {fh, 8'b0};
    if (a_side.d_zero) begin
      h2 = cap;
    end else if (a_side.r_zero) begin
      h2 = '0;
    end else if (a_quo > NB'(cap)) begin
      h2 = cap;
    end else begin
      h2 = a_quo[H_W-1:0];
    end
    mid    = fh[FH_W-1:1];
    half   = h2[H_W-1:1];
    ls2    = (half >= (H_W-1)'(mid)) ? '0 : ROW_W'((H_W-1)'(mid) - half);
    le_sum = H_W'(mid) + H_W'(half);
    if (le_sum >= H_W'(fh)) begin
      le_c = (fh == '0) ? '0 : fh - 1'b1;
    end else begin
      le_c = le_sum[FH_W-1:0];
    end
    le2 = le_c[FH_W-1] ? '1 : le_c[ROW_W-1:0];

    // only the fraction of the hit point matters
    offl  = a_side.r_zero ? '0 : b_quo[FRAC_BITS-1:0];
    frac  = b_side.rb_neg ? b_side.pb[FRAC_BITS-1:0] - offl
                          : b_side.pb[FRAC_BITS-1:0] + offl;
    tprod = TP_W'(frac) * TP_W'(tw);
    t0    = tprod[TP_W-1:FRAC_BITS];
    tm    = b_side.mirror ? tw - t0 - 1'b1 : t0;
    if (tw == '0) begin
      tx2 = '0;
    end else begin
      tx2 = tm[TEX_W-1] ? '1 : tm[TX_W-1:0];
    end
  end

  logic    s2_valid;
  side_s_t s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= a_valid && b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side.col <= a_side.col;
      s2_side.ls  <= ls2;
      s2_side.le  <= le2;
      s2_side.h   <= h2;
      s2_side.tx  <= tx2;
    end
  end

  // ---------------- texture step division ----------------
  logic               st_valid;
  logic [STEP_NQ-1:0] st_quo;
  side_s_t            st_side;

  rcw_div_chain #(.NQ(STEP_NQ), .DW(H_W), .SW($bits(side_s_t))) u_div_step (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s2_valid),
    .in_num   ({th, OUT_FRAC'(0)}),
    .in_div   (s2_side.h),
    .in_side  (s2_side),
    .out_valid(st_valid),
    .out_quo  (st_quo),
    .out_side (st_side)
  );

  // ---------------- stage 3: step and start offset ----------------
  logic signed [H_W+1:0] n2;
  logic [H_W+1:0]        n2_neg;

  always_comb begin
    n2 = $signed({10'b0, st_side.ls, 1'b0}) - $signed({10'b0, fh})
       + $signed({2'b0, st_side.h});
    n2_neg = -n2;
  end

  logic           s3_valid;
  side_s_t        s3_side;
  logic [Q_W-1:0] s3_step;
  logic           s3_neg;
  logic [H_W:0]   s3_nmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side <= st_side;
      // zero height: step saturates
      s3_step <= (st_side.h == '0) ? '1 : Q_W'(st_quo);
      s3_neg  <= n2[H_W+1];
      s3_nmag <= n2[H_W+1] ? n2_neg[H_W:0] : n2[H_W:0];
    end
  end

  // ---------------- stage 4: start product ----------------
  logic            s4_valid;
  side_s_t         s4_side;
  logic [Q_W-1:0]  s4_step;
  logic            s4_neg;
  logic [PM_W-1:0] s4_pm;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side <= s3_side;
      s4_step <= s3_step;
      s4_neg  <= s3_neg;
      s4_pm   <= PM_W'(s3_nmag) * PM_W'(s3_step);
    end
  end

  // ---------------- output register: halve, round, saturate ----------------
  logic [PM_W-1:0] half_pm;
  logic [Q_W-1:0]  ts;

  always_comb begin
    // negative side rounds toward minus infinity
    half_pm = s4_neg ? ((s4_pm + 1'b1) >> 1) : (s4_pm >> 1);
    if (s4_neg) begin
      ts = (half_pm > PM_W'(33'h080000000)) ? 32'h80000000 : (~half_pm[Q_W-1:0] + 1'b1);
    end else begin
      ts = (half_pm > PM_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : half_pm[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.data.column_out     <= s4_side.col;
      out_ch.data.row_first      <= s4_side.ls;
      out_ch.data.row_last       <= s4_side.le;
      out_ch.data.slice_height   <= s4_side.h;
      out_ch.data.texture_column <= s4_side.tx;
      out_ch.data.texture_step   <= s4_step;
      out_ch.data.texture_start  <= $signed(ts);
    end
  end

endmodule

[tb/raycast_wall_column_setup_test.sv]
module raycast_wall_column_setup_test;
  import rcw_pkg::*;

  // pipeline depth at FRAC_BITS = 16
  localparam int PIPE_LAT    = 78;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rcw_chan_if #(.item_t(in_item_t))  col_ch ();
  rcw_chan_if #(.item_t(out_item_t)) span_ch ();

  raycast_wall_column_setup u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (col_ch.sink),
    .out_ch    (span_ch.source)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers, updated on each write.
  bit [63:0] frame_h = 480;
  bit [63:0] tex_w   = 64;
  bit [63:0] tex_h   = 64;

  out_item_t span_q[$];     // predicted wall spans, oldest first
  int        mismatches = 0;
  int        cycles = 0;
  bit        no_idle = 1'b0; // both sides run flat out while set
  bit        hold_req = 1'b0; // asks the receiver for one long stall

  initial begin
    col_ch.valid = 1'b0;
    col_ch.data  = '0;
    span_ch.ready = 1'b0;
  end

  function automatic bit [63:0] magn(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Expected wall slice for one column hit, at the current configuration.
  function automatic out_item_t predict_span(in_item_t it);
    bit [63:0] hit_cell, pa, pb, dm, ram, rbm, cap, h, off, wall, frac, tx, stp, pm;
    longint d, ra, rb, rx, ry, mid, half, ls, le, n2, ts;
    out_item_t r;
    rx = it.ray_x;
    ry = it.ray_y;
    hit_cell = it.hit_y_side ? 64'(it.cell_y) + 64'(it.step_y_negative)
                             : 64'(it.cell_x) + 64'(it.step_x_negative);
    pa = it.hit_y_side ? 64'(it.player_y) : 64'(it.player_x);
    pb = it.hit_y_side ? 64'(it.player_x) : 64'(it.player_y);
    ra = it.hit_y_side ? ry : rx;
    rb = it.hit_y_side ? rx : ry;
    d = longint'(hit_cell << 16) - longint'(pa);
    dm = magn(d);
    ram = magn(ra);
    rbm = magn(rb);
    cap = frame_h * 256;
    // slice height; zero distance saturates, zero ray on the axis gives 0
    if (dm == 0) begin
      h = cap;
    end else if (ram == 0) begin
      h = 0;
    end else begin
      h = frame_h * ram / dm;
      if (h > cap) h = cap;
    end
    mid = longint'(frame_h / 2);
    half = longint'(h / 2);
    ls = mid - half;
    le = mid + half;
    if (ls < 0) ls = 0;
    if (le >= longint'(frame_h)) le = longint'(frame_h) - 1;
    if (le < 0) le = 0;
    // hit point along the face; with no ray on the axis use player_b
    off = (ram != 0) ? dm * rbm / ram : 0;
    wall = (rb < 0) ? pb - off : pb + off;
    frac = wall & 64'hFFFF;
    tx = 0;
    if (tex_w != 0) begin
      tx = (frac * tex_w) >> 16;
      if ((!it.hit_y_side && rx > 0) || (it.hit_y_side && ry < 0)) tx = tex_w - tx - 1;
      if (tx > 1023) tx = 1023;
    end
    if (h == 0) begin
      stp = 64'hFFFF_FFFF;
    end else begin
      stp = (tex_h << 16) / h;
      if (stp > 64'hFFFF_FFFF) stp = 64'hFFFF_FFFF;
    end
    n2 = 2 * ls - longint'(frame_h) + longint'(h);
    pm = magn(n2) * stp;
    ts = (n2 < 0) ? -longint'((pm + 1) >> 1) : longint'(pm >> 1);
    if (ts > 64'sd2147483647) ts = 64'sd2147483647;
    if (ts < -64'sd2147483648) ts = -64'sd2147483648;
    r.column_out     = it.column;
    r.row_first      = ROW_W'(ls > 2047 ? 2047 : ls);
    r.row_last       = ROW_W'(le > 2047 ? 2047 : le);
    r.slice_height   = H_W'(h);
    r.texture_column = TX_W'(tx);
    r.texture_step   = Q_W'(stp);
    r.texture_start  = Q_W'(ts);
    return r;
  endfunction

  // Input side: every accepted column gets its prediction queued.
  always @(posedge clk) begin
    if (!rst && col_ch.valid && col_ch.ready) span_q.push_back(predict_span(col_ch.data));
  end

  // Output side: compare each accepted span with the oldest prediction.
  always @(posedge clk) begin
    out_item_t exp_s;
    if (!rst && span_ch.valid && span_ch.ready) begin
      if (span_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected span for column %0d", span_ch.data.column_out);
      end else begin
        exp_s = span_q.pop_front();
        if (exp_s.column_out !== span_ch.data.column_out ||
            exp_s.row_first !== span_ch.data.row_first ||
            exp_s.row_last !== span_ch.data.row_last ||
            exp_s.slice_height !== span_ch.data.slice_height ||
            exp_s.texture_column !== span_ch.data.texture_column ||
            exp_s.texture_step !== span_ch.data.texture_step ||
            exp_s.texture_start !== span_ch.data.texture_start) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("span mismatch col/ls/le/h/tx/step/start exp %0d %0d %0d %0d %0d %h %h",
                     exp_s.column_out, exp_s.row_first, exp_s.row_last, exp_s.slice_height,
                     exp_s.texture_column, exp_s.texture_step, exp_s.texture_start);
            $display("                                        got %0d %0d %0d %0d %0d %h %h",
                     span_ch.data.column_out, span_ch.data.row_first, span_ch.data.row_last,
                     span_ch.data.slice_height, span_ch.data.texture_column,
                     span_ch.data.texture_step, span_ch.data.texture_start);
          end
        end
      end
    end
  end

  // Receiver: random stall per span, plus one long hold-off on request.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        span_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        span_ch.ready <= 1'b1;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 6);
        if (stall > 0) begin
          span_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
          span_ch.ready <= 1'b1;
        end else begin
          span_ch.ready <= 1'b1;
        end
      end
      do @(posedge clk); while (!(span_ch.valid && span_ch.ready) && !hold_req);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one column; returns on the falling edge after acceptance.
  task automatic send_column(in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      col_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    col_ch.valid <= 1'b1;
    col_ch.data  <= it;
    do @(posedge clk); while (!col_ch.ready);
    @(negedge clk);
  endtask

  // Wait until every span is back, leaving the block idle for a write.
  task automatic drain();
    col_ch.valid <= 1'b0;
    while (span_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_FRAME_HEIGHT:   frame_h = 64'(val & 32'hFFF);
      REG_TEXTURE_WIDTH:  tex_w   = 64'(val & 32'h7FF);
      REG_TEXTURE_HEIGHT: tex_h   = 64'(val & 32'h7FF);
      default: ;
    endcase
  endtask

  task automatic set_view(int unsigned fh, int unsigned tw, int unsigned th);
    drain();
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_TEXTURE_WIDTH, tw);
    write_reg(REG_TEXTURE_HEIGHT, th);
  endtask

  // Random column hit. Most put the player a short way from the hit face,
  // as a real ray walk does; some are raw noise or land on special cases.
  function automatic in_item_t random_column();
    in_item_t it;
    int unsigned pick, face;
    logic [23:0] near;
    it.column = COL_W'($urandom);
    it.hit_y_side = 1'($urandom);
    it.cell_x = CELL_W'($urandom);
    it.cell_y = CELL_W'($urandom);
    it.player_x = POS_W'($urandom);
    it.player_y = POS_W'($urandom);
    it.ray_x = RAY_W'($urandom);
    it.ray_y = RAY_W'($urandom);
    it.step_x_negative = 1'($urandom);
    it.step_y_negative = 1'($urandom);
    pick = $urandom_range(0, 9);
    if (pick <= 6) begin
      it.ray_x = it.ray_x >>> $urandom_range(0, 4);
      it.ray_y = it.ray_y >>> $urandom_range(0, 4);
    end
    face = it.hit_y_side ? it.cell_y + it.step_y_negative : it.cell_x + it.step_x_negative;
    near = 24'(face << 16) - 24'($urandom_range(0, (1 << $urandom_range(0, 21)) - 1));
    if (pick <= 5 || pick == 7) begin
      if (pick == 7) near = 24'(face << 16);   // zero distance
      if (it.hit_y_side) it.player_y = near;
      else it.player_x = near;
    end
    if (pick == 8) begin                       // no ray on the hit axis
      if (it.hit_y_side) it.ray_y = '0;
      else it.ray_x = '0;
    end
    return it;
  endfunction

  function automatic in_item_t make_hit(bit yside, int unsigned cx, int unsigned cy,
                                        int unsigned px, int unsigned py,
                                        int rx, int ry, bit sxn, bit syn);
    in_item_t it;
    it.column = COL_W'($urandom);
    it.hit_y_side = yside;
    it.cell_x = CELL_W'(cx);
    it.cell_y = CELL_W'(cy);
    it.player_x = POS_W'(px);
    it.player_y = POS_W'(py);
    it.ray_x = RAY_W'(rx);
    it.ray_y = RAY_W'(ry);
    it.step_x_negative = sxn;
    it.step_y_negative = syn;
    return it;
  endfunction

  task automatic test_directed();
    in_item_t it;
    // one face per side and ray sign, so both mirrored faces show up
    send_column(make_hit(0, 5, 3, 32'h0_3_8000, 32'h0_3_4000, 32'sh1_0000, 32'sh0_4000, 0, 0));
    send_column(make_hit(0, 5, 3, 32'h0_7_8000, 32'h0_3_4000, -32'sh1_0000, 32'sh0_4000, 1, 0));
    send_column(make_hit(1, 5, 3, 32'h0_5_4000, 32'h0_1_8000, 32'sh0_4000, 32'sh1_0000, 0, 0));
    send_column(make_hit(1, 5, 3, 32'h0_5_4000, 32'h0_6_8000, -32'sh0_4000, -32'sh1_0000, 0, 1));
    // zero distance on both faces
    send_column(make_hit(0, 9, 2, 32'h0_9_0000, 32'h0_2_1234, 32'sh2_0000, 32'sh1_0000, 0, 0));
    send_column(make_hit(1, 9, 2, 32'h0_9_1234, 32'h0_3_0000, 32'sh1_0000, -32'sh2_0000, 0, 1));
    // zero ray on the hit axis: no height, saturated step
    send_column(make_hit(0, 9, 2, 32'h0_3_0000, 32'h0_2_ABCD, 0, -32'sh1_0000, 0, 0));
    send_column(make_hit(1, 9, 2, 32'h0_9_5555, 32'h0_7_0000, 32'sh1_0000, 0, 0, 1));
    // largest rays; the first, at a tiny distance, has a height above the cap
    send_column(make_hit(0, 10, 0, 32'h0_9_FFFF, 0, 32'sh7_FFFF, -32'sh8_0000, 0, 0));
    send_column(make_hit(1, 0, 10, 0, 32'h0_A_0001, -32'sh8_0000, -32'sh8_0000, 1, 1));
    // field extremes
    send_column(make_hit(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_column(make_hit(1, 255, 255, 24'hFF_FFFF, 24'hFF_FFFF, 32'sh7_FFFF, 32'sh7_FFFF, 1, 1));
    send_column(make_hit(0, 255, 255, 24'hFF_FFFF, 24'hFF_FFFF, -32'sh8_0000, -32'sh8_0000, 1, 1));
    send_column(make_hit(1, 0, 0, 0, 0, 1, -1, 0, 0));
    send_column(make_hit(0, 255, 0, 0, 24'hFF_FFFF, -1, 1, 0, 1));
    it = make_hit(0, 128, 1, 24'h80_0001, 24'h01_FFFF, 32'sh0_0001, 32'sh7_FFFF, 0, 0);
    it.column = 12'hFFF;
    send_column(it);
    it.column = 12'h000;
    it.hit_y_side = 1'b1;
    send_column(it);
  endtask

  task automatic test_random(int count, bit fast);
    no_idle = fast;
    repeat (count) send_column(random_column());
    no_idle = 1'b0;
  endtask

  // Receiver stalls for a long stretch while columns keep coming: the
  // pipeline fills and the input must hold off.
  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_req = 1'b1;
    repeat (200) send_column(random_column());
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(200, 1'b0);
    test_backpressure();

    // smallest frame and textures
    set_view(2, 1, 1);
    test_directed();
    test_random(150, 1'b0);

    // largest frame and textures
    set_view(2048, 1024, 1024);
    test_directed();
    test_random(150, 1'b1);

    // odd frame height, textures not a power of two
    set_view(481, 37, 100);
    test_random(200, 1'b0);

    repeat (3) begin
      set_view($urandom_range(2, 2048), $urandom_range(1, 1024), $urandom_range(1, 1024));
      test_random(120, 1'b0);
    end

    drain();
    repeat (PIPE_LAT + 20) @(negedge clk);
    if (mismatches == 0 && span_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
